### rtl/rlos_pkg.sv
// Shared constants, payload types and control structs for the ranked list block.
`timescale 1ns / 1ps
package rlos_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int ID_SPACE    = 65536;

  // fixed field widths
  localparam int ACT_W  = 2;
  localparam int ID_W   = 16;
  localparam int RANK_W = 13;

  // derived storage widths
  localparam int SLOT_W     = $clog2(MAX_ENTRIES);
  localparam int LINK_W     = $clog2(MAX_ENTRIES + 1);
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int NODE_W     = SLOT_W + 1;
  localparam int LEAF_BASE  = 1 << SLOT_W;
  localparam int TREE_DEPTH = 2 * LEAF_BASE;
  localparam int LVL_W      = $clog2(SLOT_W + 1);
  localparam int SOI_AW     = (ID_SPACE > (1 << ID_W)) ? ID_W : $clog2(ID_SPACE);

  localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(MAX_ENTRIES);

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD     = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_OVERTAKE = 2'd2,
    ACT_QUERY    = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [ID_W-1:0]     entry_id;
    logic [RANK_W-1:0]   rank_k;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] found_id;
    logic            bad_request;
  } out_item_t;

  typedef enum logic [1:0] {
    TM_INC,
    TM_DEC,
    TM_SEL,
    TM_PEEK
  } tree_mode_t;

  typedef enum logic [1:0] {
    TR_IDLE,
    TR_UPD,
    TR_SEL,
    TR_PEEK
  } tree_state_t;

  typedef struct packed {
    logic              start;
    tree_mode_t        mode;
    logic [SLOT_W-1:0] slot;
    logic [RANK_W-1:0] rank;
  } tree_req_t;

  typedef struct packed {
    logic              done;
    logic              live;
    logic [SLOT_W-1:0] slot;
  } tree_rsp_t;

  typedef struct packed {
    logic              soi_we;
    logic [SOI_AW-1:0] soi_addr;
    logic [SLOT_W-1:0] soi_wdata;
    logic              ios_we;
    logic [SLOT_W-1:0] ios_addr;
    logic [ID_W-1:0]   ios_wdata;
    logic              nlv_we;
    logic [SLOT_W-1:0] nlv_addr;
    logic [LINK_W-1:0] nlv_wdata;
    logic              plv_we;
    logic [SLOT_W-1:0] plv_addr;
    logic [LINK_W-1:0] plv_wdata;
  } tbl_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] soi_q;
    logic [ID_W-1:0]   ios_q;
    logic [LINK_W-1:0] nlv_q;
    logic [LINK_W-1:0] plv_q;
  } tbl_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_B,
    S_LK_C,
    S_OV_A,
    S_OV_B,
    S_LD_A,
    S_LD_B,
    S_TREE,
    S_Q_ID,
    S_RES
  } top_state_t;

endpackage

### rtl/rlos_tree.sv
// Count tree store and its walker: path update, k-th descent and leaf peek.
`timescale 1ns / 1ps
module rlos_tree import rlos_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tree_req_t        req,
  input  logic [CNT_W-1:0] loaded_count,
  output tree_rsp_t        rsp
);

  logic [CNT_W-1:0] cnt_mem [TREE_DEPTH];

  tree_state_t        st_r, st_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic [LVL_W-1:0]   h_r, h_nxt;
  logic [RANK_W-1:0]  k_r, k_nxt;
  logic               dec_r;
  logic [CNT_W-1:0]   rd_r;
  logic               mask_r;

  logic               re, we;
  logic [NODE_W-1:0]  raddr;
  logic [LVL_W-1:0]   rh;
  logic [CNT_W-1:0]   wdata;
  logic [SLOT_W-1:0]  first_slot;
  logic               mask_nxt;
  logic [CNT_W-1:0]   cnt;
  logic               go_right;
  logic [NODE_W-1:0]  chosen;

  // a node whose first slot was never loaded reads as zero
  assign cnt        = mask_r ? '0 : rd_r;
  assign go_right   = 32'(cnt) < 32'(k_r);
  assign chosen     = go_right ? (node_r | NODE_W'(1)) : node_r;
  assign first_slot = SLOT_W'(raddr << rh);
  assign mask_nxt   = 32'(first_slot) >= 32'(loaded_count);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      // a peek answers in the state after its start and may hand over to the next walk at once
      TR_IDLE, TR_PEEK: begin
        if (req.start) begin
          unique case (req.mode)
            TM_INC, TM_DEC: st_nxt = TR_UPD;
            TM_SEL:         st_nxt = TR_SEL;
            TM_PEEK:        st_nxt = TR_PEEK;
            default:        st_nxt = TR_IDLE;
          endcase
        end else begin
          st_nxt = TR_IDLE;
        end
      end
      TR_UPD:  if (node_r == NODE_W'(1)) st_nxt = TR_IDLE;
      TR_SEL:  if (h_r == '0) st_nxt = TR_IDLE;
      default: st_nxt = TR_IDLE;
    endcase
  end

  always_comb begin
    re       = 1'b0;
    we       = 1'b0;
    raddr    = '0;
    rh       = '0;
    wdata    = '0;
    node_nxt = node_r;
    h_nxt    = h_r;
    k_nxt    = k_r;
    rsp      = '0;
    unique case (st_r)
      TR_IDLE, TR_PEEK: begin
        if (st_r == TR_PEEK) begin
          rsp.done = 1'b1;
          rsp.live = (cnt != '0);
        end
        if (req.start) begin
          re = 1'b1;
          if (req.mode == TM_SEL) begin
            raddr = NODE_W'(2);
            rh    = LVL_W'(SLOT_W - 1);
            k_nxt = req.rank;
          end else begin
            raddr = {1'b1, req.slot};
            rh    = '0;
          end
          node_nxt = raddr;
          h_nxt    = rh;
        end
      end
      TR_UPD: begin
        we    = 1'b1;
        wdata = dec_r ? (cnt - CNT_W'(1)) : (cnt + CNT_W'(1));
        if (node_r == NODE_W'(1)) begin
          rsp.done = 1'b1;
        end else begin
          re       = 1'b1;
          raddr    = node_r >> 1;
          rh       = LVL_W'(h_r + LVL_W'(1));
          node_nxt = raddr;
          h_nxt    = rh;
        end
      end
      TR_SEL: begin
        if (h_r == '0) begin
          rsp.done = 1'b1;
          rsp.slot = chosen[SLOT_W-1:0];
        end else begin
          re       = 1'b1;
          raddr    = chosen << 1;
          rh       = LVL_W'(h_r - LVL_W'(1));
          node_nxt = raddr;
          h_nxt    = rh;
          if (go_right) k_nxt = RANK_W'(32'(k_r) - 32'(cnt));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    h_r    <= h_nxt;
    k_r    <= k_nxt;
    if ((st_r == TR_IDLE || st_r == TR_PEEK) && req.start) dec_r <= (req.mode == TM_DEC);
  end

  always_ff @(posedge clk) begin
    if (we) cnt_mem[node_r] <= wdata;
    if (re) begin
      rd_r   <= cnt_mem[raddr];
      mask_r <= mask_nxt;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (st_r == TR_IDLE || st_r == TR_PEEK))
    else $error("tree start while walker busy");

  a_sel_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == TR_SEL |-> !node_r[0])
    else $error("descent read is not a left child");

  a_upd_node: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == TR_UPD |-> node_r != '0)
    else $error("path update walked past the root");

endmodule

### rtl/rlos_tbl.sv
// Lookup and link tables: slot of id, id of slot, next and previous live slot.
`timescale 1ns / 1ps
module rlos_tbl import rlos_pkg::*; (
  input  logic     clk,
  input  tbl_cmd_t cmd,
  output tbl_rsp_t rsp
);

  logic [SLOT_W-1:0] soi_mem [ID_SPACE];
  logic [ID_W-1:0]   ios_mem [MAX_ENTRIES];
  logic [LINK_W-1:0] nlv_mem [MAX_ENTRIES];
  logic [LINK_W-1:0] plv_mem [MAX_ENTRIES];

  logic [SLOT_W-1:0] soi_q_r;
  logic [ID_W-1:0]   ios_q_r;
  logic [LINK_W-1:0] nlv_q_r;
  logic [LINK_W-1:0] plv_q_r;

  always_ff @(posedge clk) begin
    if (cmd.soi_we) soi_mem[cmd.soi_addr] <= cmd.soi_wdata;
    else            soi_q_r <= soi_mem[cmd.soi_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ios_we) ios_mem[cmd.ios_addr] <= cmd.ios_wdata;
    else            ios_q_r <= ios_mem[cmd.ios_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.nlv_we) nlv_mem[cmd.nlv_addr] <= cmd.nlv_wdata;
    else            nlv_q_r <= nlv_mem[cmd.nlv_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.plv_we) plv_mem[cmd.plv_addr] <= cmd.plv_wdata;
    else            plv_q_r <= plv_mem[cmd.plv_addr];
  end

  assign rsp.soi_q = soi_q_r;
  assign rsp.ios_q = ios_q_r;
  assign rsp.nlv_q = nlv_q_r;
  assign rsp.plv_q = plv_q_r;

endmodule

### rtl/ranked_list_order_statistic.sv
// Ranked list top level: action sequencer, list counters and result register.
//
// Input channel in_valid/in_stall/in_data carries one action (load, remove,
// overtake, query) per transaction; output channel out_valid/out_stall/out_data
// returns one result for overtake and query, none for load and remove.
// The block takes one action at a time: in_stall is low only while idle.
// Steps per action, from acceptance until ready again:
//   load      table writes, then a 13-node count tree path update
//   remove    lookup, liveness check, relink, path update
//   overtake  lookup, swap of two table entries
//   query     12-level count tree descent, one node per cycle
// The count tree walker visits one node a cycle.
// A finished result sits in an output register; the sequencer returns to
// idle once that register is free, so a stalled receiver holds at most one
// result and then holds off the next result-producing action.
// Reset (rst_n low, synchronous) empties the list at once: tree nodes that
// cover only never-loaded slots read as zero, so no clearing pass is needed.
`timescale 1ns / 1ps
module ranked_list_order_statistic import rlos_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  top_state_t        st_r, st_nxt;
  action_t           act_r;
  logic [ID_W-1:0]   id_r;
  logic [ID_W-1:0]   id2_r;
  logic [SLOT_W-1:0] slot_r;
  logic [LINK_W-1:0] pred_r;
  logic [SLOT_W-1:0] tail_r;
  logic [CNT_W-1:0]  loaded_r;
  logic [CNT_W-1:0]  live_r;
  out_item_t         res_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  tree_req_t         tree_req;
  tree_rsp_t         tree_rsp;
  tbl_cmd_t          tbl_cmd;
  tbl_rsp_t          tbl_rsp;

  logic              in_acc;
  logic              out_free;
  logic              id_bad;
  logic              rank_bad;
  logic              full;
  logic              slot_ok;
  logic              entry_ok;
  logic              pred_none;
  logic              succ_none;
  logic              is_ovt;
  logic [SLOT_W-1:0] new_slot;

  rlos_tree u_tree (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (tree_req),
    .loaded_count (loaded_r),
    .rsp          (tree_rsp)
  );

  rlos_tbl u_tbl (
    .clk (clk),
    .cmd (tbl_cmd),
    .rsp (tbl_rsp)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign in_acc    = in_valid && (st_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign id_bad    = 32'(in_data.entry_id) >= 32'(ID_SPACE);
  assign rank_bad  = (in_data.rank_k == '0) || (32'(in_data.rank_k) > 32'(live_r));
  assign full      = 32'(loaded_r) >= 32'(MAX_ENTRIES);
  assign slot_ok   = 32'(tbl_rsp.soi_q) < 32'(loaded_r);
  assign entry_ok  = tree_rsp.live && (tbl_rsp.ios_q == id_r);
  assign pred_none = tbl_rsp.plv_q >= NO_SLOT;
  assign succ_none = tbl_rsp.nlv_q >= NO_SLOT;
  assign is_ovt    = (act_r == ACT_OVERTAKE);
  assign new_slot  = SLOT_W'(loaded_r);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.action)
            ACT_LOAD:     st_nxt = (full || id_bad) ? S_IDLE : S_LD_A;
            ACT_REMOVE:   st_nxt = id_bad ? S_IDLE : S_LK_B;
            ACT_OVERTAKE: st_nxt = id_bad ? S_RES : S_LK_B;
            ACT_QUERY:    st_nxt = rank_bad ? S_RES : S_TREE;
            default:      st_nxt = S_IDLE;
          endcase
        end
      end
      S_LK_B: begin
        if (slot_ok)     st_nxt = S_LK_C;
        else if (is_ovt) st_nxt = S_RES;
        else             st_nxt = S_IDLE;
      end
      S_LK_C: begin
        priority if (!entry_ok) st_nxt = is_ovt ? S_RES : S_IDLE;
        else if (!is_ovt)       st_nxt = S_TREE;
        else if (pred_none)     st_nxt = S_RES;
        else                    st_nxt = S_OV_A;
      end
      S_OV_A:  st_nxt = S_OV_B;
      S_OV_B:  st_nxt = S_RES;
      S_LD_A:  st_nxt = (live_r != '0) ? S_LD_B : S_TREE;
      S_LD_B:  st_nxt = S_TREE;
      S_TREE: begin
        if (tree_rsp.done) st_nxt = (act_r == ACT_QUERY) ? S_Q_ID : S_IDLE;
      end
      S_Q_ID:  st_nxt = S_RES;
      S_RES:   if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    tree_req = '0;
    tbl_cmd  = '0;
    unique case (st_r)
      S_IDLE: begin
        tbl_cmd.soi_addr = SOI_AW'(in_data.entry_id);
        if (in_acc && in_data.action == ACT_QUERY && !rank_bad) begin
          tree_req.start = 1'b1;
          tree_req.mode  = TM_SEL;
          tree_req.rank  = in_data.rank_k;
        end
      end
      S_LK_B: begin
        tbl_cmd.ios_addr = tbl_rsp.soi_q;
        tbl_cmd.nlv_addr = tbl_rsp.soi_q;
        tbl_cmd.plv_addr = tbl_rsp.soi_q;
        if (slot_ok) begin
          tree_req.start = 1'b1;
          tree_req.mode  = TM_PEEK;
          tree_req.slot  = tbl_rsp.soi_q;
        end
      end
      S_LK_C: begin
        if (entry_ok && !is_ovt) begin
          // unlink, testing each neighbor before touching it
          tbl_cmd.plv_we    = !succ_none;
          tbl_cmd.plv_addr  = SLOT_W'(tbl_rsp.nlv_q);
          tbl_cmd.plv_wdata = tbl_rsp.plv_q;
          tbl_cmd.nlv_we    = !pred_none;
          tbl_cmd.nlv_addr  = SLOT_W'(tbl_rsp.plv_q);
          tbl_cmd.nlv_wdata = tbl_rsp.nlv_q;
          tree_req.start    = 1'b1;
          tree_req.mode     = TM_DEC;
          tree_req.slot     = slot_r;
        end else begin
          tbl_cmd.ios_addr = SLOT_W'(tbl_rsp.plv_q);
        end
      end
      S_OV_A: begin
        tbl_cmd.soi_we    = 1'b1;
        tbl_cmd.soi_addr  = SOI_AW'(id_r);
        tbl_cmd.soi_wdata = SLOT_W'(pred_r);
        tbl_cmd.ios_we    = 1'b1;
        tbl_cmd.ios_addr  = slot_r;
        tbl_cmd.ios_wdata = tbl_rsp.ios_q;
      end
      S_OV_B: begin
        // second write wins when both ids are the same
        tbl_cmd.soi_we    = 1'b1;
        tbl_cmd.soi_addr  = SOI_AW'(id2_r);
        tbl_cmd.soi_wdata = slot_r;
        tbl_cmd.ios_we    = 1'b1;
        tbl_cmd.ios_addr  = SLOT_W'(pred_r);
        tbl_cmd.ios_wdata = id_r;
      end
      S_LD_A: begin
        tbl_cmd.ios_we    = 1'b1;
        tbl_cmd.ios_addr  = new_slot;
        tbl_cmd.ios_wdata = id_r;
        tbl_cmd.soi_we    = 1'b1;
        tbl_cmd.soi_addr  = SOI_AW'(id_r);
        tbl_cmd.soi_wdata = new_slot;
        tbl_cmd.plv_we    = 1'b1;
        tbl_cmd.plv_addr  = new_slot;
        tbl_cmd.plv_wdata = (live_r != '0) ? LINK_W'(tail_r) : NO_SLOT;
        tbl_cmd.nlv_we    = 1'b1;
        tbl_cmd.nlv_addr  = new_slot;
        tbl_cmd.nlv_wdata = NO_SLOT;
        tree_req.start    = 1'b1;
        tree_req.mode     = TM_INC;
        tree_req.slot     = new_slot;
      end
      S_LD_B: begin
        tbl_cmd.nlv_we    = 1'b1;
        tbl_cmd.nlv_addr  = tail_r;
        tbl_cmd.nlv_wdata = LINK_W'(new_slot);
      end
      S_TREE: begin
        tbl_cmd.ios_addr = tree_rsp.slot;
      end
      S_Q_ID, S_RES: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      loaded_r    <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_TREE && tree_rsp.done) begin
        if (act_r == ACT_LOAD) begin
          loaded_r <= loaded_r + CNT_W'(1);
          live_r   <= live_r + CNT_W'(1);
        end else if (act_r == ACT_REMOVE) begin
          live_r <= live_r - CNT_W'(1);
        end
      end
      if (st_r == S_RES && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)           out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_data.action;
      id_r  <= in_data.entry_id;
      res_r <= '{found_id: '0, bad_request: 1'b1};
    end
    if (st_r == S_LK_B) slot_r <= tbl_rsp.soi_q;
    if (st_r == S_LK_C) begin
      pred_r <= tbl_rsp.plv_q;
      // drop the tail back to the predecessor when the last entry goes
      if (entry_ok && !is_ovt && succ_none) tail_r <= SLOT_W'(tbl_rsp.plv_q);
    end
    if (st_r == S_OV_A) id2_r <= tbl_rsp.ios_q;
    if (st_r == S_OV_B) res_r <= '{found_id: '0, bad_request: 1'b0};
    if (st_r == S_Q_ID) res_r <= '{found_id: tbl_rsp.ios_q, bad_request: 1'b0};
    if (st_r == S_TREE && tree_rsp.done && act_r == ACT_LOAD) tail_r <= new_slot;
    if (st_r == S_RES && out_free) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_live_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= loaded_r)
    else $error("live count above loaded count");

  a_tree_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    tree_rsp.done |-> (st_r == S_TREE || st_r == S_LK_C))
    else $error("tree walker finished outside a waiting state");

  a_result_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == S_RES)
    else $error("result register loaded outside result state");

endmodule

### verif/tb.sv
// Self-checking testbench for the ranked list order-statistic block.
`timescale 1ns / 1ps
module tb;
  import rlos_pkg::*;

  class rank_scoreboard;
    bit [CNT_W-1:0]  count_tree [TREE_DEPTH];
    bit [SLOT_W-1:0] slot_of [ID_SPACE];
    bit [ID_W-1:0]   id_at [MAX_ENTRIES];
    bit [LINK_W-1:0] next_lnk [MAX_ENTRIES];
    bit [LINK_W-1:0] prev_lnk [MAX_ENTRIES];
    int              loaded;
    out_item_t       expected_results [$];
    int              mismatches;

    function new();
      loaded = 0;
      mismatches = 0;
    endfunction

    function void adjust_path(int slot, bit up);
      int node;
      node = LEAF_BASE + slot;
      while (node != 0) begin
        if (up) count_tree[node]++;
        else count_tree[node]--;
        node >>= 1;
      end
    endfunction

    // descend from the root to the k-th live leaf; k must be in 1..count_tree[1]
    function int select_rank(int k);
      int node;
      int left;
      node = 1;
      while (node < LEAF_BASE) begin
        left = node * 2;
        if (count_tree[left] < k) begin
          k -= count_tree[left];
          node = left + 1;
        end else begin
          node = left;
        end
      end
      return node - LEAF_BASE;
    endfunction

    function int live_slot_of(int id);
      int s;
      s = slot_of[id];
      if (s >= loaded) return MAX_ENTRIES;
      if (count_tree[LEAF_BASE + s] == 0 || id_at[s] != id) return MAX_ENTRIES;
      return s;
    endfunction

    function int live_total();
      return count_tree[1];
    endfunction

    function bit full();
      return loaded >= MAX_ENTRIES;
    endfunction

    function int id_of_rank(int k);
      return id_at[select_rank(k)];
    endfunction

    function void note_action(in_item_t it);
      int        s;
      int        p;
      int        q;
      int        id;
      int        id2;
      int        k;
      out_item_t res;
      id  = it.entry_id;
      k   = it.rank_k;
      res = '0;
      case (it.action)
        ACT_LOAD: begin
          if (loaded < MAX_ENTRIES) begin
            s = loaded;
            p = MAX_ENTRIES;
            if (count_tree[1] != 0) begin
              p = select_rank(count_tree[1]);
              next_lnk[p] = LINK_W'(s);
            end
            prev_lnk[s] = LINK_W'(p);
            next_lnk[s] = LINK_W'(MAX_ENTRIES);
            id_at[s]    = ID_W'(id);
            slot_of[id] = SLOT_W'(s);
            adjust_path(s, 1'b1);
            loaded = s + 1;
          end
        end
        ACT_REMOVE: begin
          s = live_slot_of(id);
          if (s < MAX_ENTRIES) begin
            p = prev_lnk[s];
            q = next_lnk[s];
            if (q < MAX_ENTRIES) prev_lnk[q] = LINK_W'(p);
            if (p < MAX_ENTRIES) next_lnk[p] = LINK_W'(q);
            adjust_path(s, 1'b0);
          end
        end
        ACT_OVERTAKE: begin
          s = live_slot_of(id);
          p = (s == MAX_ENTRIES) ? MAX_ENTRIES : int'(prev_lnk[s]);
          if (p >= MAX_ENTRIES) begin
            res.bad_request = 1'b1;
          end else begin
            // swap the two ids between their slots
            id2          = id_at[p];
            slot_of[id]  = SLOT_W'(p);
            slot_of[id2] = SLOT_W'(s);
            id_at[s]     = ID_W'(id2);
            id_at[p]     = ID_W'(id);
          end
          expected_results.push_back(res);
        end
        default: begin
          if (k == 0 || k > count_tree[1]) res.bad_request = 1'b1;
          else res.found_id = id_at[select_rank(k)];
          expected_results.push_back(res);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result found_id=%h bad_request=%b",
                   $realtime, got.found_id, got.bad_request);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.found_id !== want.found_id || got.bad_request !== want.bad_request) begin
        if (mismatches < 10)
          $display("%0t: mismatch found_id exp=%h got=%h, bad_request exp=%b got=%b",
                   $realtime, want.found_id, got.found_id, want.bad_request,
                   got.bad_request);
        mismatches++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 480;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  rank_scoreboard  sb;
  logic [ID_W-1:0] known_ids [$];
  bit              calm;
  bit              hold_req;
  int              tx_free;

  ranked_list_order_statistic dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle bursts on the sender, separated by runs of back-to-back items; no gaps while calm
  function automatic int pick_gap();
    if (calm) return 0;
    if (tx_free > 0) begin
      tx_free--;
      return 0;
    end
    tx_free = $urandom_range(0, 12);
    return $urandom_range(1, 18);
  endfunction

  // call at a falling edge; returns at the falling edge after the transaction
  task automatic send_action(input action_t act, input logic [ID_W-1:0] id,
                             input logic [RANK_W-1:0] k);
    in_item_t it;
    int       gap;
    it.action   = act;
    it.entry_id = id;
    it.rank_k   = k;
    if (act == ACT_LOAD && !sb.full()) known_ids.push_back(id);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_action(it);
    @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_known();
    return known_ids[$urandom_range(0, known_ids.size() - 1)];
  endfunction

  task automatic random_action();
    int              r;
    int              live;
    int              pick;
    logic [ID_W-1:0] id;
    logic [RANK_W-1:0] k;
    r    = $urandom_range(0, 99);
    live = sb.live_total();
    id   = ID_W'($urandom_range(0, 65535));
    k    = RANK_W'($urandom_range(0, 8191));
    if (r < 28 || known_ids.size() == 0) begin
      if (known_ids.size() != 0 && $urandom_range(0, 9) == 0) id = pick_known();
      send_action(ACT_LOAD, id, k);
    end else if (r < 46) begin
      send_action(ACT_REMOVE, pick_known(), k);
    end else if (r < 66) begin
      // now and then push the head of the list, which must be refused
      if (live > 0 && $urandom_range(0, 6) == 0) id = ID_W'(sb.id_of_rank(1));
      else id = pick_known();
      send_action(ACT_OVERTAKE, id, k);
    end else begin
      pick = $urandom_range(0, 9);
      if (live > 0 && pick < 8) k = RANK_W'($urandom_range(1, live));
      else if (pick == 8) k = $urandom_range(0, 1) ? RANK_W'(live + 1) : '0;
      send_action(ACT_QUERY, id, k);
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request; no stalls while calm
  initial begin
    int stall_left;
    int free_left;
    int hold_left;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && free_left == 0) begin
          stall_left = $urandom_range(1, 18);
          free_left  = $urandom_range(0, 40);
        end
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          free_left--;
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int live;
    sb       = new();
    calm     = 1'b0;
    hold_req = 1'b0;
    tx_free  = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, field extremes, head overtake, duplicates, dead ids
    send_action(ACT_QUERY, 16'h0000, 13'd1);
    send_action(ACT_QUERY, 16'hFFFF, 13'd0);
    send_action(ACT_LOAD, 16'h0000, 13'h1FFF);
    send_action(ACT_LOAD, 16'hFFFF, 13'd0);
    send_action(ACT_LOAD, 16'h5555, 13'h0AAA);
    send_action(ACT_LOAD, 16'hAAAA, 13'h1555);
    send_action(ACT_QUERY, 16'h0000, 13'd1);
    send_action(ACT_QUERY, 16'h0000, 13'd4);
    send_action(ACT_QUERY, 16'h0000, 13'd5);
    send_action(ACT_QUERY, 16'hFFFF, 13'h1FFF);
    send_action(ACT_OVERTAKE, 16'h0000, 13'd0);
    send_action(ACT_OVERTAKE, 16'hAAAA, 13'd0);
    send_action(ACT_QUERY, 16'h0000, 13'd3);
    send_action(ACT_LOAD, 16'h0000, 13'd0);
    send_action(ACT_REMOVE, 16'hFFFF, 13'd0);
    send_action(ACT_REMOVE, 16'hFFFF, 13'd0);
    send_action(ACT_OVERTAKE, 16'hFFFF, 13'd0);
    send_action(ACT_QUERY, 16'h0000, 13'd2);
    send_action(ACT_QUERY, 16'h0000, 13'd5);
    send_action(ACT_REMOVE, 16'h0000, 13'd0);
    send_action(ACT_QUERY, 16'h0000, 13'd4);
    send_action(ACT_QUERY, 16'h0000, 13'd4096);
    send_action(ACT_OVERTAKE, 16'h5555, 13'd0);
    send_action(ACT_QUERY, 16'h0000, 13'd1);

    // random mix; the receiver holds off early so the block backs up
    hold_req = 1'b1;
    repeat (RANDOM_ITEMS) random_action();

    // no idling from here: probe the rank bounds, then a last random mix
    calm = 1'b1;
    live = sb.live_total();
    send_action(ACT_QUERY, 16'h0000, RANK_W'(live));
    send_action(ACT_QUERY, 16'h0000, RANK_W'(live + 1));
    send_action(ACT_QUERY, 16'h0000, 13'd4096);
    send_action(ACT_QUERY, 16'h0000, 13'd1);
    send_action(ACT_QUERY, 16'h0000, 13'h1FFF);
    repeat (40) random_action();
    in_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/rlos_pkg.sv
rtl/rlos_tree.sv
rtl/rlos_tbl.sv
rtl/ranked_list_order_statistic.sv
verif/tb.sv
